// ===== rtl/sdro_pkg.sv =====
// Package for the SCAN disk request scheduler: word types, codes and defaults.
// Depends on nothing; every other file of the block imports it.
package sdro_pkg;

    localparam int TRACK_W           = 12;
    localparam int MAX_REQUESTS_DEF  = 16;
    localparam logic [TRACK_W-1:0] LAST_TRACK_RESET = 12'd199;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_RUN  = 1'b1;
    localparam logic DIR_DOWN = 1'b0;
    localparam logic DIR_UP   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [TRACK_W-1:0] track_value;
        logic               direction;
    } req_t;

    typedef struct packed {
        logic [TRACK_W-1:0] track_out;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

// ===== rtl/sdro_cmp.sv =====
// Shared track comparator of the scheduler, used by every insertion step.
// Depends on sdro_pkg.
module sdro_cmp (
    input  logic [sdro_pkg::TRACK_W-1:0] a,
    input  logic [sdro_pkg::TRACK_W-1:0] b,
    output sdro_pkg::cmp_res_t           res
);
    import sdro_pkg::*;

    assign res.gt = (a > b);
    assign res.eq = (a == b);

endmodule

// ===== rtl/sdro_mem.sv =====
// Track store of the scheduler: one write port, one registered read port.
// Depends on sdro_pkg.
module sdro_mem #(
    parameter int DEPTH = sdro_pkg::MAX_REQUESTS_DEF + 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [sdro_pkg::TRACK_W-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic [sdro_pkg::TRACK_W-1:0] rdata
);
    import sdro_pkg::*;

    logic [TRACK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/scan_disk_request_order.sv =====
// Top level of the SCAN (elevator) disk request scheduler: sequencer and config register.
// Depends on sdro_pkg, sdro_cmp and sdro_mem.
//
//  channel   ports                 handshake
//  --------  --------------------  ----------------------------------------
//  request   start, busy, req      word taken when start && !busy
//  result    rsp_valid, rsp        one word per cycle of rsp_valid, no stall
//  config    cfg_we, cfg_wdata     disk_last_track written when cfg_we
//
// The store is kept sorted: an add shifts larger entries up one per cycle through
// the single memory port and comparator.
// A run inserts the end marker and the start the same way, then streams n + 2 tracks,
// one per cycle, each in the cycle after its memory read.
// Reset clears the count, sequencer and register; store contents need no reset.
// Results cannot be stalled; busy drops in the cycle that carries the last word.
module scan_disk_request_order #(
    parameter int MAX_REQUESTS = sdro_pkg::MAX_REQUESTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  sdro_pkg::req_t               req,
    input  logic                         cfg_we,
    input  logic [sdro_pkg::TRACK_W-1:0] cfg_wdata,
    output logic                         rsp_valid,
    output sdro_pkg::rsp_t               rsp
);
    import sdro_pkg::*;

    localparam int DEPTH = MAX_REQUESTS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_INS_CHK, ST_INS_CMP, ST_EMIT} state_t;
    typedef enum logic [1:0] {INS_ADD, INS_MARK, INS_START} ins_stage_t;

    state_t             state_reg, state_next;
    ins_stage_t         stage_reg, stage_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [TRACK_W-1:0] key_reg, key_next;
    logic [TRACK_W-1:0] start_reg, start_next;
    logic               dir_reg, dir_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               last_reg, last_next;
    logic [TRACK_W-1:0] disk_last_track_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TRACK_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [TRACK_W-1:0] mem_rdata;
    cmp_res_t           cmp_res;

    sdro_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sdro_cmp u_cmp (
        .a   (mem_rdata),
        .b   (key_reg),
        .res (cmp_res)
    );

    always_comb
    begin
        logic ins_done;
        logic do_shift;
        logic at_end;

        state_next     = state_reg;
        stage_next     = stage_reg;
        k_next         = k_reg;
        key_next       = key_reg;
        start_next     = start_reg;
        dir_next       = dir_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        rsp_valid_next = 1'b0;
        last_next      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = k_reg;
        mem_wdata      = key_reg;
        mem_raddr      = k_reg - 1'b1;
        ins_done       = 1'b0;
        // the start is inserted below equal tracks so its slot is the first holding it
        do_shift       = cmp_res.gt | ((stage_reg == INS_START) & cmp_res.eq);
        at_end         = (dir_reg == DIR_UP) ? (CW'(idx_reg) == n_reg - 1'b1)
                                             : (idx_reg == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.cmd == CMD_RUN)
                    begin
                        key_next   = (req.direction == DIR_UP) ? disk_last_track_reg : '0;
                        start_next = req.track_value;
                        dir_next   = req.direction;
                        stage_next = INS_MARK;
                        k_next     = AW'(n_reg);
                        state_next = ST_INS_CHK;
                    end
                    else if (n_reg < CW'(MAX_REQUESTS))
                    begin
                        key_next   = (req.track_value > disk_last_track_reg) ?
                                     disk_last_track_reg : req.track_value;
                        stage_next = INS_ADD;
                        k_next     = AW'(n_reg);
                        state_next = ST_INS_CHK;
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (k_reg == '0)
                begin
                    ins_done = 1'b1;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (do_shift)
                begin
                    // move the larger entry up and fetch the one below it
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    mem_raddr  = k_reg - 2'd2;
                    k_next     = k_reg - 1'b1;
                    if (k_reg == AW'(1))
                    begin
                        state_next = ST_INS_CHK;
                    end
                end
                else
                begin
                    ins_done = 1'b1;
                end
            end
            ST_EMIT:
            begin
                mem_raddr      = idx_reg;
                rsp_valid_next = 1'b1;
                last_next      = (rem_reg == CW'(1));
                rem_next       = rem_reg - 1'b1;
                if (!phase_reg && at_end)
                begin
                    // turn around past the start slot
                    idx_next   = (dir_reg == DIR_UP) ? pos_reg - 1'b1 : pos_reg + 1'b1;
                    phase_next = 1'b1;
                end
                else if (dir_reg ^ phase_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
                if (rem_reg == CW'(1))
                begin
                    n_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ins_done)
        begin
            mem_we = 1'b1;
            n_next = n_reg + 1'b1;
            unique case (stage_reg)
                INS_ADD:
                begin
                    state_next = ST_IDLE;
                end
                INS_MARK:
                begin
                    key_next   = start_reg;
                    k_next     = AW'(n_reg + 1'b1);
                    stage_next = INS_START;
                    state_next = ST_INS_CHK;
                end
                INS_START:
                begin
                    pos_next   = k_reg;
                    idx_next   = k_reg;
                    phase_next = 1'b0;
                    rem_next   = n_reg + 1'b1;
                    state_next = ST_EMIT;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= INS_ADD;
            n_reg         <= '0;
            rem_reg       <= '0;
            phase_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            n_reg         <= n_next;
            rem_reg       <= rem_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        key_reg   <= key_next;
        start_reg <= start_next;
        dir_reg   <= dir_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_last_track_reg <= LAST_TRACK_RESET;
        end
        else if (cfg_we)
        begin
            disk_last_track_reg <= cfg_wdata;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign rsp.track_out = mem_rdata;
    assign rsp.last      = last_reg;

`ifndef NO_ASSERTIONS
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(state_reg == ST_EMIT))
        else $error("result word without a preceding emit cycle");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last) |=> !rsp_valid)
        else $error("result word after the last word of a run");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (n_reg <= CW'(MAX_REQUESTS)))
        else $error("request count above capacity while idle");

    a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("emit with no words remaining");
`endif

endmodule
